@@ rtl/sdd_pkg.sv @@
package sdd_pkg;

    localparam int COORD_BITS = 12;
    localparam int FOCAL_W    = 24;
    localparam int PRIN_W     = 20;
    localparam int BASE_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int CENTRE_W = COORD_BITS + 2;
    localparam int D_W      = CENTRE_W;
    localparam int A_W      = CENTRE_W + 7;
    localparam int DIFF_W   = (A_W > PRIN_W) ? A_W : PRIN_W;
    localparam int PZ_W     = FOCAL_W + BASE_W;
    localparam int PL_W     = DIFF_W + BASE_W;
    localparam int PROD_W   = (PZ_W > PL_W) ? PZ_W : PL_W;
    localparam int NUM_W    = PROD_W - 7;

    localparam int Q_W      = 29;
    localparam int TOP_W    = NUM_W - Q_W;
    localparam int CMP_W    = (TOP_W > D_W) ? TOP_W : D_W;
    localparam logic [Q_W-1:0] COMP_CAP = Q_W'(1) << (Q_W - 1);

    localparam int SQ_W     = 2 * Q_W;
    localparam int SUM_W    = SQ_W;
    localparam int ROOT_W   = SUM_W / 2;

    localparam int DIST_W   = 20;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam int DIV_LAT  = Q_W + 1;
    localparam int SQRT_LAT = ROOT_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOCAL = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    typedef struct packed {
        logic valid;
        logic nocal;
        logic zero;
    } t_ctl;

endpackage

@@ rtl/sdd_div.sv @@
module sdd_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [sdd_pkg::NUM_W-1:0]    i_num,
    input  logic [sdd_pkg::D_W-1:0]      i_den,
    output logic [sdd_pkg::Q_W-1:0]      o_quot
);

    localparam int QW = sdd_pkg::Q_W;
    localparam int DW = sdd_pkg::D_W;

    logic [DW-1:0] r_rem  [QW+1];
    logic [QW-1:0] r_work [QW+1];
    logic [DW-1:0] r_den  [QW+1];
    logic          r_ovf  [QW+1];

    logic [DW-1:0] n_rem  [QW];
    logic [QW-1:0] n_work [QW];
    logic [DW:0]   n_t    [QW];
    logic [sdd_pkg::TOP_W-1:0] n_top;

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            n_t[k] = {r_rem[k], r_work[k][QW-1]};
            if (n_t[k] >= {1'b0, r_den[k]}) begin
                n_rem[k]  = DW'(n_t[k] - {1'b0, r_den[k]});
                n_work[k] = {r_work[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k]  = DW'(n_t[k]);
                n_work[k] = {r_work[k][QW-2:0], 1'b0};
            end
        end
    end

    assign n_top = i_num[sdd_pkg::NUM_W-1:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= DW'(n_top);
            r_work[0] <= i_num[QW-1:0];
            r_den[0]  <= i_den;
            r_ovf[0]  <= sdd_pkg::CMP_W'(n_top) >= sdd_pkg::CMP_W'(i_den);
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_work[k+1] <= n_work[k];
                r_den[k+1]  <= r_den[k];
                r_ovf[k+1]  <= r_ovf[k];
            end
        end
    end

    assign o_quot = (r_ovf[QW] || r_work[QW] > sdd_pkg::COMP_CAP) ? sdd_pkg::COMP_CAP
                                                                 : r_work[QW];

endmodule

@@ rtl/sdd_sqrt.sv @@
module sdd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sdd_pkg::SUM_W-1:0]     i_rad,
    output logic [sdd_pkg::ROOT_W-1:0]    o_root
);

    localparam int RW = sdd_pkg::ROOT_W;
    localparam int SW = sdd_pkg::SUM_W;

    logic [SW-1:0] r_rad  [RW+1];
    logic [RW:0]   r_rem  [RW+1];
    logic [RW-1:0] r_root [RW+1];

    logic [RW+2:0] n_t     [RW];
    logic [RW+2:0] n_trial [RW];
    logic [RW:0]   n_rem   [RW];
    logic [RW-1:0] n_root  [RW];

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            n_t[k]     = {r_rem[k], r_rad[k][SW-1:SW-2]};
            n_trial[k] = {1'b0, r_root[k], 2'b01};
            if (n_t[k] >= n_trial[k]) begin
                n_rem[k]  = (RW+1)'(n_t[k] - n_trial[k]);
                n_root[k] = {r_root[k][RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = (RW+1)'(n_t[k]);
                n_root[k] = {r_root[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int k = 0; k < RW; k++) begin
                r_rad[k+1]  <= {r_rad[k][SW-3:0], 2'b00};
                r_rem[k+1]  <= n_rem[k];
                r_root[k+1] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[RW];

endmodule

@@ rtl/stereo_distance_from_disparity.sv @@
// Stereo distance from one matched pair of boxes.
// Input channel: i_valid / o_stall carry one word of six box fields; a word is
// taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry distance_mm and status; a word is
// delivered at a rising edge with o_valid high and i_stall low.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write focal length, principal
// point x and y, baseline and the calibrated flag; write only while idle.
// Pipeline from acceptance to o_valid: an input stage, a multiply stage, a
// 30-stage restoring divider (a load stage, then one quotient bit per stage), a
// square stage, a sum stage, a 30-stage square root (a load stage, then one root
// bit per stage) and the output register.
// Throughput: one word per cycle while the receiver does not stall.
// Stall: a stalled result holds the whole pipeline; nothing is lost or repeated
// and the input channel stalls in the same cycle.
// Reset: all valid bits and configuration registers clear; the block reports
// not calibrated until the calibrated flag is written.
module stereo_distance_from_disparity (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sdd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sdd_pkg::COORD_BITS-1:0]    i_left_x,
    input  logic [sdd_pkg::COORD_BITS-1:0]    i_left_y,
    input  logic [sdd_pkg::COORD_BITS-1:0]    i_left_width,
    input  logic [sdd_pkg::COORD_BITS-1:0]    i_left_height,
    input  logic [sdd_pkg::COORD_BITS-1:0]    i_right_x,
    input  logic [sdd_pkg::COORD_BITS-1:0]    i_right_width,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sdd_pkg::DIST_W-1:0]        o_distance_mm,
    output logic [1:0]                        o_status
);

    localparam int CW = sdd_pkg::CENTRE_W;
    localparam int DFW = sdd_pkg::DIFF_W;

    logic [sdd_pkg::FOCAL_W-1:0] r_focal;
    logic [sdd_pkg::PRIN_W-1:0]  r_px;
    logic [sdd_pkg::PRIN_W-1:0]  r_py;
    logic [sdd_pkg::BASE_W-1:0]  r_base;
    logic                        r_cal;

    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= '0;
            r_px    <= '0;
            r_py    <= '0;
            r_base  <= '0;
            r_cal   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdd_pkg::CFG_FOCAL: r_focal <= i_cfg_data[sdd_pkg::FOCAL_W-1:0];
                sdd_pkg::CFG_PX:    r_px    <= i_cfg_data[sdd_pkg::PRIN_W-1:0];
                sdd_pkg::CFG_PY:    r_py    <= i_cfg_data[sdd_pkg::PRIN_W-1:0];
                sdd_pkg::CFG_BASE:  r_base  <= i_cfg_data[sdd_pkg::BASE_W-1:0];
                sdd_pkg::CFG_CAL:   r_cal   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic [CW-1:0]  n_xl2, n_yl2, n_xr2, n_d2;
    logic [DFW-1:0] n_ax, n_ay, n_dx, n_dy;

    always_comb begin
        n_xl2 = CW'({i_left_x, 1'b0}) + CW'(i_left_width);
        n_yl2 = CW'({i_left_y, 1'b0}) + CW'(i_left_height);
        n_xr2 = CW'({i_right_x, 1'b0}) + CW'(i_right_width);
        n_d2  = (n_xl2 >= n_xr2) ? (n_xl2 - n_xr2) : (n_xr2 - n_xl2);
        n_ax  = DFW'({n_xl2, 7'b0});
        n_ay  = DFW'({n_yl2, 7'b0});
        n_dx  = (n_ax >= DFW'(r_px)) ? (n_ax - DFW'(r_px)) : (DFW'(r_px) - n_ax);
        n_dy  = (n_ay >= DFW'(r_py)) ? (n_ay - DFW'(r_py)) : (DFW'(r_py) - n_ay);
    end

    sdd_pkg::t_ctl r_ctl_a, r_ctl_b, r_ctl_c, r_ctl_d;
    sdd_pkg::t_ctl r_ctl_div [sdd_pkg::DIV_LAT];
    sdd_pkg::t_ctl r_ctl_sq  [sdd_pkg::SQRT_LAT];

    logic [CW-1:0]  r_d2_a, r_d2_b;
    logic [DFW-1:0] r_dx_a, r_dy_a;
    logic [sdd_pkg::NUM_W-1:0] r_num_z, r_num_x, r_num_y;
    logic [sdd_pkg::Q_W-1:0]   w_qz, w_qx, w_qy;
    logic [sdd_pkg::SQ_W-1:0]  r_sq_z, r_sq_x, r_sq_y;
    logic [sdd_pkg::SUM_W-1:0] r_sum;
    logic [sdd_pkg::ROOT_W-1:0] w_root;

    logic [sdd_pkg::PROD_W-1:0] n_pz, n_px, n_py;

    always_comb begin
        n_pz = sdd_pkg::PROD_W'(r_focal) * sdd_pkg::PROD_W'(r_base);
        n_px = sdd_pkg::PROD_W'(r_dx_a) * sdd_pkg::PROD_W'(r_base);
        n_py = sdd_pkg::PROD_W'(r_dy_a) * sdd_pkg::PROD_W'(r_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
            r_ctl_d <= '0;
            for (int k = 0; k < sdd_pkg::DIV_LAT; k++) r_ctl_div[k] <= '0;
            for (int k = 0; k < sdd_pkg::SQRT_LAT; k++) r_ctl_sq[k] <= '0;
        end else if (en) begin
            r_ctl_a.valid <= i_valid;
            r_ctl_a.nocal <= !r_cal;
            r_ctl_a.zero  <= (n_d2 == '0);
            r_ctl_b       <= r_ctl_a;
            r_ctl_div[0]  <= r_ctl_b;
            for (int k = 1; k < sdd_pkg::DIV_LAT; k++) r_ctl_div[k] <= r_ctl_div[k-1];
            r_ctl_c       <= r_ctl_div[sdd_pkg::DIV_LAT-1];
            r_ctl_d       <= r_ctl_c;
            r_ctl_sq[0]   <= r_ctl_d;
            for (int k = 1; k < sdd_pkg::SQRT_LAT; k++) r_ctl_sq[k] <= r_ctl_sq[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_a  <= n_d2;
            r_dx_a  <= n_dx;
            r_dy_a  <= n_dy;
            r_d2_b  <= r_d2_a;
            r_num_z <= sdd_pkg::NUM_W'(n_pz >> 7);
            r_num_x <= sdd_pkg::NUM_W'(n_px >> 7);
            r_num_y <= sdd_pkg::NUM_W'(n_py >> 7);
            r_sq_z  <= sdd_pkg::SQ_W'(w_qz) * sdd_pkg::SQ_W'(w_qz);
            r_sq_x  <= sdd_pkg::SQ_W'(w_qx) * sdd_pkg::SQ_W'(w_qx);
            r_sq_y  <= sdd_pkg::SQ_W'(w_qy) * sdd_pkg::SQ_W'(w_qy);
            r_sum   <= r_sq_z + r_sq_x + r_sq_y;
        end
    end

    sdd_div u_div_z (.i_clk(i_clk), .i_en(en), .i_num(r_num_z), .i_den(r_d2_b), .o_quot(w_qz));
    sdd_div u_div_x (.i_clk(i_clk), .i_en(en), .i_num(r_num_x), .i_den(r_d2_b), .o_quot(w_qx));
    sdd_div u_div_y (.i_clk(i_clk), .i_en(en), .i_num(r_num_y), .i_den(r_d2_b), .o_quot(w_qy));

    sdd_sqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_rad(r_sum), .o_root(w_root));

    sdd_pkg::t_ctl            w_ctl_e;
    logic [sdd_pkg::ROOT_W-9:0] w_mm;
    logic [sdd_pkg::DIST_W-1:0] n_dist;
    logic [1:0]               n_status;
    logic                     r_valid;
    logic [sdd_pkg::DIST_W-1:0] r_dist;
    logic [1:0]               r_status;

    always_comb begin
        w_ctl_e = r_ctl_sq[sdd_pkg::SQRT_LAT-1];
        w_mm    = w_root[sdd_pkg::ROOT_W-1:8];
        if (w_ctl_e.nocal) begin
            n_dist   = '0;
            n_status = sdd_pkg::ST_NOCAL;
        end else if (w_ctl_e.zero) begin
            n_dist   = sdd_pkg::DIST_MAX;
            n_status = sdd_pkg::ST_ZERO;
        end else begin
            n_dist   = (w_mm > (sdd_pkg::ROOT_W-8)'(sdd_pkg::DIST_MAX)) ? sdd_pkg::DIST_MAX
                                                                     : sdd_pkg::DIST_W'(w_mm);
            n_status = sdd_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= w_ctl_e.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist   <= n_dist;
            r_status <= n_status;
        end
    end

    assign o_valid       = r_valid;
    assign o_distance_mm = r_dist;
    assign o_status      = r_status;

endmodule
